[hw/rtl/wiegand_frame_receiver_unit_defines.svh]
// Assertion helpers for the frame receiver.
`ifndef WIEGAND_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define WIEGAND_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clock, masked in reset.
`define WFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, masked in reset.
`define WFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/wfr_pkg.sv]
`default_nettype none

package wfr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned IDX_W    = 6;
   localparam int unsigned FBITS_W  = 9;
   localparam int unsigned BIDX_W   = 5;
   localparam int unsigned TIME_W   = 24;
   localparam int unsigned MAXB_W   = 6;
   localparam int unsigned MAX_RSP  = 32;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 24'd25000;
   localparam logic [TIME_W-1:0] IDLE_MAX      = 24'hFFFFFF;

   typedef enum logic [1:0] {
      OP_D0   = 2'd0,
      OP_D1   = 2'd1,
      OP_TICK = 2'd2,
      OP_READ = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_SINGLE,
      RD_ISSUE,
      RD_LOAD
   } rd_state_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic               start;
      logic               pending;
      logic [IDX_W-1:0]   n;
      logic [FBITS_W-1:0] bits;
   } rd_cmd_type;

   typedef struct packed {
      logic rd_en;
      logic clear;
      logic busy;
   } rd_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/wiegand_frame_receiver_unit.sv]
// Wiegand frame receiver. D0 and D1 pulse words shift a 0 or a 1, MSB first, into a byte
// store of BUFFER_BYTES entries; tick words advance a saturating idle counter that every
// pulse restarts. A read word finds a frame once the idle count is above the timeout and
// bits have been captured; it then streams up to min(bits/8+1, max_bytes, BUFFER_BYTES, 32)
// byte words and clears the store, or else answers with a single word. Pulse and tick words
// are taken one per cycle while no read is in progress: each pulse is a read-modify-write of
// the store, with a registered read and the write in the cycle after it, and the next pulse
// is forwarded around that write. A read word holds the input while busy, in RD_SINGLE for a
// single word or in RD_ISSUE then RD_LOAD for each byte streamed, as the store's single read
// port serves one byte at a time, and longer while the result side stalls. The store needs
// no clearing pass after reset: per-entry valid bits make unwritten bytes read as zero.
`default_nettype none
`include "wiegand_frame_receiver_unit_defines.svh"

module wiegand_frame_receiver_unit #(
   parameter int unsigned BUFFER_BYTES = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [wfr_pkg::TIME_W-1:0]  csr_write_data,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [wfr_pkg::MAXB_W-1:0]  req_max_bytes,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [wfr_pkg::FBITS_W-1:0]      rsp_frame_bits,
   output logic [wfr_pkg::BYTE_W-1:0]       rsp_byte_value,
   output logic [wfr_pkg::BIDX_W-1:0]       rsp_byte_index,
   output logic                             rsp_has_data,
   output logic                             rsp_last
);
   import wfr_pkg::*;

   localparam int unsigned AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int unsigned BW    = $clog2(BUFFER_BYTES * 8 + 1);
   localparam int unsigned PW    = BW - 3;
   localparam int unsigned CW    = (PW + 1 > 7) ? PW + 1 : 7;
   localparam int unsigned LIMIT = (BUFFER_BYTES < MAX_RSP) ? BUFFER_BYTES : MAX_RSP;

   logic [TIME_W-1:0] timeout_ff;
   logic [TIME_W-1:0] idle_ff;
   logic [TIME_W-1:0] idle_in;
   logic [BW-1:0]     bit_total_ff;
   logic [BW-1:0]     bit_total_in;
   logic [PW-1:0]     pos;
   logic              full;
   logic              accept;
   logic              is_pulse;
   logic              shift_go;
   opcode_type        op;
   logic [CW-1:0]     cnt_a;
   logic [CW-1:0]     cnt_b;
   logic [CW-1:0]     cnt_c;
   logic [CW-1:0]     cnt_ab;
   logic [CW-1:0]     cnt_n;
   store_wr_type      wr;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rdr_addr;
   logic [AW-1:0]     rd_addr;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data;
   rd_cmd_type        cmd;
   rd_ctl_type        ctl;

   assign op        = opcode_type'(req_opcode);
   assign req_ready = !ctl.busy;
   assign accept    = req_valid && req_ready;
   assign is_pulse  = (op == OP_D0) || (op == OP_D1);
   assign pos       = bit_total_ff[BW-1:3];
   assign full      = (pos >= PW'(BUFFER_BYTES));
   assign shift_go  = accept && is_pulse && !full;

   // bytes to stream: min of captured bytes plus one, caller limit and store size capped at MAX_RSP
   always_comb begin
      cnt_a  = CW'(pos) + 1'b1;
      cnt_b  = CW'(req_max_bytes);
      cnt_c  = CW'(LIMIT);
      cnt_ab = (cnt_a < cnt_b) ? cnt_a : cnt_b;
      cnt_n  = (cnt_ab < cnt_c) ? cnt_ab : cnt_c;
   end

   assign cmd.start   = accept && (op == OP_READ);
   assign cmd.pending = (idle_ff > timeout_ff) && (bit_total_ff != '0);
   assign cmd.n       = IDX_W'(cnt_n);
   assign cmd.bits    = FBITS_W'(bit_total_ff);

   always_comb begin
      idle_in      = idle_ff;
      bit_total_in = bit_total_ff;
      if (accept) begin
         case (op)
            OP_D0, OP_D1: begin
               idle_in = '0;
               if (!full) begin
                  bit_total_in = BW'(bit_total_ff + 1'b1);
               end
            end
            OP_TICK: begin
               if (idle_ff != IDLE_MAX) begin
                  idle_in = idle_ff + 1'b1;
               end
            end
            default: begin
               idle_in = idle_ff;
            end
         endcase
      end
      if (ctl.clear) begin
         bit_total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         idle_ff      <= '0;
         bit_total_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
         idle_ff      <= idle_in;
         bit_total_ff <= bit_total_in;
      end
   end

   assign rd_en   = shift_go || ctl.rd_en;
   assign rd_addr = ctl.rd_en ? rdr_addr : pos[AW-1:0];

   wfr_store #(
      .DEPTH (BUFFER_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (ctl.clear),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wfr_shifter #(
      .AW (AW)
   ) u_shifter (
      .clock   (clock),
      .reset   (reset),
      .go      (shift_go),
      .bit_val (op == OP_D1),
      .addr    (pos[AW-1:0]),
      .rd_data (rd_data),
      .wr      (wr),
      .wr_addr (wr_addr)
   );

   wfr_reader #(
      .AW (AW)
   ) u_reader (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_data        (rd_data),
      .ctl            (ctl),
      .rd_addr        (rdr_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_bits (rsp_frame_bits),
      .rsp_byte_value (rsp_byte_value),
      .rsp_byte_index (rsp_byte_index),
      .rsp_has_data   (rsp_has_data),
      .rsp_last       (rsp_last)
   );

   `WFR_ASSERT_NEXT(a_pulse_restarts_idle, accept && is_pulse, idle_ff == '0, "idle count not restarted by pulse")
   `WFR_ASSERT_NEXT(a_pulse_counts_bit, shift_go, bit_total_ff == BW'($past(bit_total_ff) + 1'b1), "bit count not advanced")
   `WFR_ASSERT_NEXT(a_full_drops_bit, accept && is_pulse && full, $stable(bit_total_ff), "bit taken into full store")
   `WFR_ASSERT_NEXT(a_clear_empties, ctl.clear, bit_total_ff == '0 && req_ready, "frame not released after read")

endmodule

`default_nettype wire

[hw/rtl/wfr_store.sv]
`default_nettype none

module wfr_store #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = 5
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      clear,
   input  wire wfr_pkg::store_wr_type     wr,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic [wfr_pkg::BYTE_W-1:0]     rd_data
);
   import wfr_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;
   logic [BYTE_W-1:0] rd_data_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (clear) begin
         vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/wfr_shifter.sv]
`default_nettype none

module wfr_shifter #(
   parameter int unsigned AW = 5
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      go,
   input  wire logic                      bit_val,
   input  wire logic [AW-1:0]             addr,
   input  wire logic [wfr_pkg::BYTE_W-1:0] rd_data,
   output wfr_pkg::store_wr_type          wr,
   output logic [AW-1:0]                  wr_addr
);
   import wfr_pkg::*;

   logic              s1_vld_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic              s1_bit_ff;
   logic              fwd_vld_ff;
   logic [AW-1:0]     fwd_addr_ff;
   logic [BYTE_W-1:0] fwd_data_ff;
   logic [BYTE_W-1:0] old_byte;
   logic [BYTE_W-1:0] new_byte;

   // take the byte written on the edge that sampled this read
   always_comb begin
      old_byte = (fwd_vld_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data;
      new_byte = {old_byte[BYTE_W-2:0], s1_bit_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= go;
         fwd_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= addr;
      s1_bit_ff   <= bit_val;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= new_byte;
   end

   assign wr.en   = s1_vld_ff;
   assign wr.data = new_byte;
   assign wr_addr = s1_addr_ff;

endmodule

`default_nettype wire

[hw/rtl/wfr_reader.sv]
`default_nettype none

module wfr_reader #(
   parameter int unsigned AW = 5
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire wfr_pkg::rd_cmd_type         cmd,
   input  wire logic [wfr_pkg::BYTE_W-1:0]  rd_data,
   output wfr_pkg::rd_ctl_type              ctl,
   output logic [AW-1:0]                    rd_addr,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [wfr_pkg::FBITS_W-1:0]      rsp_frame_bits,
   output logic [wfr_pkg::BYTE_W-1:0]       rsp_byte_value,
   output logic [wfr_pkg::BIDX_W-1:0]       rsp_byte_index,
   output logic                             rsp_has_data,
   output logic                             rsp_last
);
   import wfr_pkg::*;

   rd_state_type       state_ff;
   rd_state_type       state_in;
   logic [IDX_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [FBITS_W-1:0] bits_ff;
   logic               hit_ff;
   logic               out_free;
   logic               last_byte;
   logic               load_single;
   logic               load_byte;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [FBITS_W-1:0] rsp_bits_ff;
   logic [BYTE_W-1:0]  rsp_byte_ff;
   logic [BIDX_W-1:0]  rsp_idx_ff;
   logic               rsp_has_ff;
   logic               rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_byte = (IDX_W'(idx_ff + 1'b1) == cnt_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RD_IDLE: begin
            if (cmd.start) begin
               state_in = (cmd.pending && (cmd.n != '0)) ? RD_ISSUE : RD_SINGLE;
            end
         end
         RD_SINGLE: begin
            if (out_free) begin
               state_in = RD_IDLE;
            end
         end
         RD_ISSUE: begin
            state_in = RD_LOAD;
         end
         RD_LOAD: begin
            if (out_free) begin
               state_in = last_byte ? RD_IDLE : RD_ISSUE;
            end
         end
         default: begin
            state_in = RD_IDLE;
         end
      endcase
   end

   always_comb begin
      load_single = 1'b0;
      load_byte   = 1'b0;
      ctl         = '0;
      case (state_ff)
         RD_IDLE: begin
            ctl.busy = 1'b0;
         end
         RD_SINGLE: begin
            ctl.busy    = 1'b1;
            load_single = out_free;
            ctl.clear   = out_free && hit_ff;
         end
         RD_ISSUE: begin
            ctl.busy  = 1'b1;
            ctl.rd_en = 1'b1;
         end
         RD_LOAD: begin
            ctl.busy  = 1'b1;
            load_byte = out_free;
            ctl.clear = out_free && last_byte;
         end
         default: begin
            ctl.busy = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = load_single || load_byte || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RD_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == RD_IDLE) && cmd.start) begin
         cnt_ff  <= cmd.n;
         bits_ff <= cmd.pending ? cmd.bits : '0;
         hit_ff  <= cmd.pending;
         idx_ff  <= '0;
      end else if (load_byte) begin
         idx_ff <= IDX_W'(idx_ff + 1'b1);
      end
      if (load_single) begin
         rsp_bits_ff <= bits_ff;
         rsp_byte_ff <= '0;
         rsp_idx_ff  <= '0;
         rsp_has_ff  <= 1'b0;
         rsp_last_ff <= 1'b1;
      end else if (load_byte) begin
         rsp_bits_ff <= bits_ff;
         rsp_byte_ff <= rd_data;
         rsp_idx_ff  <= BIDX_W'(idx_ff);
         rsp_has_ff  <= 1'b1;
         rsp_last_ff <= last_byte;
      end
   end

   assign rd_addr        = idx_ff[AW-1:0];
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_bits = rsp_bits_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_byte_index = rsp_idx_ff;
   assign rsp_has_data   = rsp_has_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
